[hw/rtl/uvtg_pkg.sv]
package uvtg_pkg;

   localparam int SEC_W   = 32;
   localparam int USEC_W  = 20;
   localparam int ADJ_W   = 4;
   localparam int SEQ_W   = 13;
   localparam int NODE_W  = 48;
   localparam int STAMP_W = 60;
   localparam int TICK_W  = 24;

   // Register indexes on the configuration port.
   localparam logic CSR_NODE_ADDRESS   = 1'b0;
   localparam logic CSR_CLOCK_SEQ_SEED = 1'b1;

   localparam logic [SEQ_W-1:0]   SEQ_SEED_RESET   = 13'd1;
   localparam logic [ADJ_W-1:0]   ADJUST_LIMIT     = 4'd10;
   localparam logic [TICK_W-1:0]  TICKS_PER_SECOND = 24'd10_000_000;
   localparam logic [3:0]         UUID_VERSION     = 4'h1;
   localparam logic [2:0]         UUID_VARIANT     = 3'b100;

   // 100 ns ticks between 15 October 1582 and 1 January 1970.
   localparam logic [STAMP_W-1:0] EPOCH_OFFSET = 60'h1B2_1DD2_1381_4000;

   // One timestamp request travelling from the admission logic to the stamp unit.
   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [USEC_W-1:0] microseconds;
      logic [ADJ_W-1:0]  adjust;
   } stamp_req_type;

   // Timestamp fields as they appear in the UUID.
   typedef struct packed {
      logic [31:0] stamp_low;
      logic [15:0] stamp_mid;
      logic [15:0] time_high_version;
   } stamp_fields_type;

endpackage

[hw/rtl/uvtg_stamp.sv]
module uvtg_stamp
   import uvtg_pkg::*;
(
   input  stamp_req_type    req,
   output stamp_fields_type fields
);

   logic [SEC_W+TICK_W-1:0] sec_ticks;
   logic [TICK_W-1:0]       usec_ticks;
   logic [STAMP_W-1:0]      stamp;

   // Microseconds times ten, as two shifted copies.
   assign usec_ticks = TICK_W'({req.microseconds, 3'b000}) + TICK_W'({req.microseconds, 1'b0});
   assign sec_ticks  = (SEC_W+TICK_W)'(req.seconds) * (SEC_W+TICK_W)'(TICKS_PER_SECOND);

   // The sum wraps at 60 bits by construction.
   assign stamp = STAMP_W'(sec_ticks) + STAMP_W'(usec_ticks) + STAMP_W'(req.adjust)
                + EPOCH_OFFSET;

   assign fields.stamp_low         = stamp[31:0];
   assign fields.stamp_mid         = stamp[47:32];
   assign fields.time_high_version = {UUID_VERSION, stamp[59:48]};

endmodule

[hw/rtl/uuid_v1_time_generator_core.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   seconds, microseconds
// rsp       out        rsp_valid/rsp_stall   time low/mid/high+version, clock seq, node
// csr       in         csr_write_enable      csr_index, csr_write_data (no read-back)
//
// One request is taken per clock while req_stall is low. It is registered at its transfer
// edge and its UUID is then loaded into the output register, which drives rsp_valid.
// A repeated time past the tenth adjustment step is taken and dropped without a result.
// Reset is synchronous and active high; it clears the generator state and
// loads the register defaults (node address zero, clock sequence seed one).
// A stall on rsp reaches req_stall only when both the admission and output stages are full.
module uuid_v1_time_generator_core
   import uvtg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SEC_W-1:0]  req_seconds,
   input  logic [USEC_W-1:0] req_microseconds,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_time_low_field,
   output logic [15:0]       rsp_time_mid_field,
   output logic [15:0]       rsp_time_high_version,
   output logic [15:0]       rsp_clock_seq_field,
   output logic [NODE_W-1:0] rsp_node_field,

   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [NODE_W-1:0] csr_write_data
);

   // Configuration registers.
   logic [NODE_W-1:0] node_ff;
   logic [SEQ_W-1:0]  seed_ff;

   // Generator state.
   logic              started_ff, started_in;
   logic [SEC_W-1:0]  last_sec_ff, last_sec_in;
   logic [USEC_W-1:0] last_usec_ff, last_usec_in;
   logic [ADJ_W-1:0]  adj_ff, adj_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   // Admission stage.
   logic              s1_valid_ff, s1_valid_in;
   stamp_req_type     s1_req_ff, s1_req_in;
   logic [SEQ_W-1:0]  s1_seq_ff, s1_seq_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   stamp_fields_type  out_fields_ff;
   logic [SEQ_W-1:0]  out_seq_ff;
   logic [NODE_W-1:0] out_node_ff;

   logic              req_xfer;
   logic              out_load;
   logic              s1_load;
   logic              time_older;
   logic              time_same;
   logic              emit;
   logic [SEQ_W-1:0]  seq_step;
   logic [SEQ_W-1:0]  seed_nz;
   stamp_fields_type  stamp_fields;

   // The output register can take a new word when it is empty or being drained;
   // the admission stage can take a request when it is empty or moving forward.
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_xfer  = req_valid && !req_stall;
   assign s1_load   = !s1_valid_ff || out_load;

   // Configuration writes are to arrive only while the pipeline is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         seed_ff <= SEQ_SEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_ADDRESS:   node_ff <= csr_write_data;
            CSR_CLOCK_SEQ_SEED: seed_ff <= csr_write_data[SEQ_W-1:0];
            default:            node_ff <= node_ff;
         endcase
      end
   end

   // Time ordering against the last accepted reading, seconds first.
   assign time_older = (req_seconds < last_sec_ff) ||
                       ((req_seconds == last_sec_ff) && (req_microseconds < last_usec_ff));
   assign time_same  = (req_seconds == last_sec_ff) && (req_microseconds == last_usec_ff);

   // Once started, the clock sequence never takes the value zero.
   assign seq_step = (seq_ff + SEQ_W'(1) == '0) ? SEQ_W'(1) : seq_ff + SEQ_W'(1);
   assign seed_nz  = (seed_ff == '0) ? SEQ_W'(1) : seed_ff;

   // A repeated time that has used up all adjustment steps gives no result.
   assign emit = !started_ff || !time_same || (adj_ff < ADJUST_LIMIT);

   always_comb begin
      started_in   = started_ff;
      last_sec_in  = last_sec_ff;
      last_usec_in = last_usec_ff;
      adj_in       = adj_ff;
      seq_in       = seq_ff;
      if (req_xfer) begin
         if (!started_ff) begin
            started_in   = 1'b1;
            seq_in       = seed_nz;
            adj_in       = '0;
            last_sec_in  = req_seconds;
            last_usec_in = req_microseconds;
         end else if (time_older) begin
            seq_in       = seq_step;
            adj_in       = '0;
            last_sec_in  = req_seconds;
            last_usec_in = req_microseconds;
         end else if (time_same) begin
            if (adj_ff < ADJUST_LIMIT) begin
               adj_in = adj_ff + ADJ_W'(1);
            end
         end else begin
            adj_in       = '0;
            last_sec_in  = req_seconds;
            last_usec_in = req_microseconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         last_sec_ff  <= '0;
         last_usec_ff <= '0;
         adj_ff       <= '0;
         seq_ff       <= '0;
      end else begin
         started_ff   <= started_in;
         last_sec_ff  <= last_sec_in;
         last_usec_ff <= last_usec_in;
         adj_ff       <= adj_in;
         seq_ff       <= seq_in;
      end
   end

   // Admission stage: the request with its adjustment and clock sequence as
   // they stand after this transfer.
   always_comb begin
      s1_req_in.seconds      = req_seconds;
      s1_req_in.microseconds = req_microseconds;
      s1_req_in.adjust       = adj_in;
      s1_seq_in              = seq_in;
      s1_valid_in            = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = req_xfer && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= s1_req_in;
         s1_seq_ff <= s1_seq_in;
      end
   end

   uvtg_stamp u_stamp (
      .req    (s1_req_ff),
      .fields (stamp_fields)
   );

   // Output register: holds its word steady while the consumer stalls.
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_fields_ff <= stamp_fields;
         out_seq_ff    <= s1_seq_ff;
         out_node_ff   <= node_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_time_low_field    = out_fields_ff.stamp_low;
   assign rsp_time_mid_field    = out_fields_ff.stamp_mid;
   assign rsp_time_high_version = out_fields_ff.time_high_version;
   assign rsp_clock_seq_field   = {UUID_VARIANT, out_seq_ff};
   assign rsp_node_field        = out_node_ff;

`ifndef SYNTH
   // The adjustment counter never runs past its limit.
   a_adjust_bounded: assert property (@(posedge clock) disable iff (reset)
      adj_ff <= ADJUST_LIMIT)
      else $error("sub-tick adjustment exceeded its limit");

   // Once running, the clock sequence is never zero.
   a_seq_nonzero: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (seq_ff != '0))
      else $error("clock sequence is zero after start");

   // An exhausted repeat of the same time leaves the generator state untouched
   // and sends nothing into the pipeline.
   a_exhausted_drop: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && started_ff && time_same && (adj_ff == ADJUST_LIMIT))
      |=> ($stable(adj_ff) && $stable(seq_ff) && !s1_valid_ff))
      else $error("exhausted repeat changed state or produced a result");

   // The clock sequence moves only with a transfer on the request channel.
   a_seq_moves_on_xfer: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(seq_ff))
      else $error("clock sequence changed without a request transfer");
`endif

endmodule

[test/uuid_stamp_checker.sv]
module uuid_stamp_checker
   import uvtg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [SEC_W-1:0]  req_seconds,
   input  logic [USEC_W-1:0] req_microseconds,

   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [31:0]       rsp_time_low_field,
   input  logic [15:0]       rsp_time_mid_field,
   input  logic [15:0]       rsp_time_high_version,
   input  logic [15:0]       rsp_clock_seq_field,
   input  logic [NODE_W-1:0] rsp_node_field,

   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [NODE_W-1:0] csr_write_data,

   output int                expected_left,
   output int                failures
);

   localparam logic [63:0] TICKS_100NS_PER_SEC = 64'd10_000_000;
   localparam logic [63:0] GREGORIAN_OFFSET    = 64'h01B2_1DD2_1381_4000;

   typedef struct packed {
      logic [31:0]       low_word;
      logic [15:0]       mid_word;
      logic [15:0]       time_hi_ver;
      logic [15:0]       clk_seq;
      logic [NODE_W-1:0] node;
   } uuid_fields_type;

   // Register copies as the block should hold them.
   logic [NODE_W-1:0] node_cfg;
   logic [SEQ_W-1:0]  seed_cfg;

   // Generator state.
   logic              gen_started;
   logic [SEC_W-1:0]  prev_sec;
   logic [USEC_W-1:0] prev_usec;
   logic [ADJ_W-1:0]  tick_adjust;
   logic [SEQ_W-1:0]  clk_sequence;

   uuid_fields_type   pending_uuids[$];
   int                mismatch_count;

   function automatic logic [SEQ_W-1:0] skip_zero(input logic [SEQ_W-1:0] v);
      return (v == '0) ? SEQ_W'(1) : v;
   endfunction

   // Advances the generator state for one reading. Returns 1 and fills in
   // the UUID when one is due, 0 when a repeated reading is dropped.
   function automatic bit next_uuid(input logic [SEC_W-1:0] sec,
                                    input logic [USEC_W-1:0] usec,
                                    output uuid_fields_type u);
      logic [63:0] ticks;
      u = '0;
      if (!gen_started) begin
         clk_sequence = skip_zero(seed_cfg);
         gen_started  = 1'b1;
         tick_adjust  = '0;
         prev_sec     = sec;
         prev_usec    = usec;
      end else if (sec < prev_sec || (sec == prev_sec && usec < prev_usec)) begin
         clk_sequence = skip_zero(clk_sequence + SEQ_W'(1));
         tick_adjust  = '0;
         prev_sec     = sec;
         prev_usec    = usec;
      end else if (sec == prev_sec && usec == prev_usec) begin
         if (tick_adjust >= ADJUST_LIMIT) return 1'b0;
         tick_adjust = tick_adjust + ADJ_W'(1);
      end else begin
         tick_adjust = '0;
         prev_sec    = sec;
         prev_usec   = usec;
      end
      ticks = 64'(sec) * TICKS_100NS_PER_SEC + 64'(usec) * 64'd10
            + 64'(tick_adjust) + GREGORIAN_OFFSET;
      u.low_word    = ticks[31:0];
      u.mid_word    = ticks[47:32];
      u.time_hi_ver = {4'h1, ticks[59:48]};
      u.clk_seq     = {3'b100, clk_sequence};
      u.node        = node_cfg;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      uuid_fields_type want;
      uuid_fields_type made;
      if (reset) begin
         node_cfg       = '0;
         seed_cfg       = SEQ_SEED_RESET;
         gen_started    = 1'b0;
         prev_sec       = '0;
         prev_usec      = '0;
         tick_adjust    = '0;
         clk_sequence   = '0;
         mismatch_count = 0;
         pending_uuids.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_NODE_ADDRESS) node_cfg = csr_write_data;
            else if (csr_index == CSR_CLOCK_SEQ_SEED) seed_cfg = csr_write_data[SEQ_W-1:0];
         end
         // Results are retired before new readings are predicted, so a result
         // can never be matched against the reading taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (pending_uuids.size() == 0) begin
               $error("unexpected UUID transfer: time_low_field %h", rsp_time_low_field);
               mismatch_count++;
            end else begin
               want = pending_uuids.pop_front();
               if (rsp_time_low_field !== want.low_word) begin
                  $error("time_low_field mismatch: expected %h, actual %h",
                         want.low_word, rsp_time_low_field);
                  mismatch_count++;
               end
               if (rsp_time_mid_field !== want.mid_word) begin
                  $error("time_mid_field mismatch: expected %h, actual %h",
                         want.mid_word, rsp_time_mid_field);
                  mismatch_count++;
               end
               if (rsp_time_high_version !== want.time_hi_ver) begin
                  $error("time_high_version mismatch: expected %h, actual %h",
                         want.time_hi_ver, rsp_time_high_version);
                  mismatch_count++;
               end
               if (rsp_clock_seq_field !== want.clk_seq) begin
                  $error("clock_seq_field mismatch: expected %h, actual %h",
                         want.clk_seq, rsp_clock_seq_field);
                  mismatch_count++;
               end
               if (rsp_node_field !== want.node) begin
                  $error("node_field mismatch: expected %h, actual %h",
                         want.node, rsp_node_field);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (next_uuid(req_seconds, req_microseconds, made))
               pending_uuids.push_back(made);
         end
      end
      expected_left <= pending_uuids.size();
      failures      <= mismatch_count;
   end

endmodule

[test/uuid_v1_time_generator_core_tb.sv]
module uuid_v1_time_generator_core_tb;
   import uvtg_pkg::*;

   // Cycles with no transfer on either channel before the run is abandoned.
   // The longest quiet stretch of a correct run is the receiver hold-off plus
   // a few idle or stall runs, far below this.
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles the receiver holds off in the pressure test; well above the
   // depth of the two pipeline stages, so the request side has to stall.
   localparam int HOLDOFF_CYCLES = 40;
   // Quiet cycles after the last expected UUID before the registers are
   // written again.
   localparam int SETTLE_CYCLES  = 8;

   logic              clock;
   logic              reset;

   logic              req_valid;
   logic              req_stall;
   logic [SEC_W-1:0]  req_seconds;
   logic [USEC_W-1:0] req_microseconds;

   logic              rsp_valid;
   logic              rsp_stall;
   logic [31:0]       rsp_time_low_field;
   logic [15:0]       rsp_time_mid_field;
   logic [15:0]       rsp_time_high_version;
   logic [15:0]       rsp_clock_seq_field;
   logic [NODE_W-1:0] rsp_node_field;

   logic              csr_write_enable;
   logic              csr_index;
   logic [NODE_W-1:0] csr_write_data;

   int                expected_left;
   int                failures;

   // Percent of cycles in which the sender idles and the receiver stalls.
   int                tx_idle_pct;
   int                rx_stall_pct;

   // The receiver serves one hold-off each time the request count moves on.
   int                holdoffs_requested;
   int                holdoffs_served;

   // Last reading sent, used to build well-formed time sequences.
   logic [SEC_W-1:0]  clk_sec;
   int                clk_usec;

   uuid_v1_time_generator_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_seconds          (req_seconds),
      .req_microseconds     (req_microseconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_time_low_field   (rsp_time_low_field),
      .rsp_time_mid_field   (rsp_time_mid_field),
      .rsp_time_high_version(rsp_time_high_version),
      .rsp_clock_seq_field  (rsp_clock_seq_field),
      .rsp_node_field       (rsp_node_field),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // The checker watches both channels and the register port, predicts each
   // UUID and compares it; this module only produces stimulus and the verdict.
   uuid_stamp_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_seconds          (req_seconds),
      .req_microseconds     (req_microseconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_time_low_field   (rsp_time_low_field),
      .rsp_time_mid_field   (rsp_time_mid_field),
      .rsp_time_high_version(rsp_time_high_version),
      .rsp_clock_seq_field  (rsp_clock_seq_field),
      .rsp_node_field       (rsp_node_field),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .expected_left        (expected_left),
      .failures             (failures)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver. Each cycle it stalls at random at the current rate. When a
   // hold-off is requested it keeps rsp_stall high for the whole hold-off,
   // while the sender goes on offering readings.
   initial begin
      holdoffs_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs_requested != holdoffs_served) begin
            holdoffs_served++;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Watchdog: a correct run never goes this long without a transfer.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Writes one register. The enable is dropped for a cycle afterwards so
   // that back-to-back writes never assign it twice in one time step.
   task automatic write_csr(input logic idx, input logic [NODE_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one reading after a random number of idle cycles and returns at
   // the edge on which the transfer happens. The payload holds while stalled.
   task automatic send_reading(input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_seconds      <= sec;
      req_microseconds <= usec;
      clk_sec          = sec;
      clk_usec         = usec;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   // Stops offering and waits until every predicted UUID has been taken, then
   // lets the pipeline settle before the registers are written again.
   // The first edge lets the checker's count catch up with the last transfer.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Moves the running clock reading one step: mostly forward, sometimes
   // backward, sometimes to a fully random time, sometimes not at all.
   task automatic step_clock;
      int pick;
      int delta;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if ($urandom_range(3) == 0) begin
            clk_sec  = clk_sec + SEC_W'($urandom_range(1, 5));
            clk_usec = $urandom_range(0, 999999);
         end else begin
            clk_usec = clk_usec + $urandom_range(1, 1000);
            if (clk_usec > 999999) begin
               clk_usec = clk_usec - 1000000;
               clk_sec  = clk_sec + 1;
            end
         end
      end else if (pick < 70) begin
         delta = $urandom_range(1, 1000);
         if ($urandom_range(3) == 0) clk_sec = clk_sec - SEC_W'($urandom_range(1, 3));
         else if (clk_usec >= delta) clk_usec = clk_usec - delta;
         else begin
            clk_sec  = clk_sec - 1;
            clk_usec = clk_usec + 1000000 - delta;
         end
      end else if (pick < 82) begin
         // Full-range reading: every bit of both fields, including
         // microsecond values past 999999.
         clk_sec  = $urandom;
         clk_usec = $urandom_range(0, 20'hFFFFF);
      end
   endtask

   // Sends random runs of readings until roughly the given number of UUIDs
   // is due. Runs of one reading dominate; longer runs of the same reading
   // walk the sub-tick adjustment up to its limit and beyond.
   task automatic random_readings(input int uuid_goal);
      int due;
      int reps;
      due = 0;
      while (due < uuid_goal) begin
         step_clock();
         reps = ($urandom_range(99) < 80) ? 1 : $urandom_range(2, 13);
         repeat (reps) send_reading(clk_sec, USEC_W'(clk_usec));
         due += (reps > 11) ? 11 : reps;
      end
   endtask

   initial begin
      tx_idle_pct        = 35;
      rx_stall_pct       = 65;
      holdoffs_requested = 0;
      clk_sec            = '0;
      clk_usec           = 0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_seconds        <= '0;
      req_microseconds   <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_NODE_ADDRESS;
      csr_write_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The seed only matters before the first reading. Its upper bits are
      // set to show they are masked; the low 13 bits are all ones, so the
      // first backward step wraps the sequence through zero to one.
      write_csr(CSR_NODE_ADDRESS, '0);
      write_csr(CSR_CLOCK_SEQ_SEED, {NODE_W{1'b1}});

      // Directed part. The first reading loads the sequence from the seed,
      // then the same reading repeats until the adjustment saturates at ten
      // and two more repeats are dropped.
      repeat (13) send_reading('0, '0);
      send_reading('0, 20'd1);                    // forward by one microsecond
      send_reading('0, '0);                       // backward: sequence wraps
      send_reading('0, '0);                       // repeat after a backward step
      send_reading(32'hFFFF_FFFF, 20'd999_999);   // largest regular time
      send_reading(32'hFFFF_FFFF, 20'hF_FFFF);    // microseconds past range
      send_reading(32'hFFFF_FFFF, 20'hF_FFFF);    // repeat at the top of range
      send_reading(32'h8000_0000, 20'd999_999);   // backward by seconds
      send_reading(32'h8000_0000, 20'd0);         // backward within a second
      send_reading(32'h8000_0001, 20'd0);         // forward by seconds
      drain();

      // First random phase: the sender idles less than the receiver stalls.
      write_csr(CSR_NODE_ADDRESS, {NODE_W{1'b1}});
      write_csr(CSR_CLOCK_SEQ_SEED, 48'd8191);
      random_readings(350);
      drain();

      // Second random phase: the sender idles more than the receiver stalls.
      tx_idle_pct  = 65;
      rx_stall_pct = 35;
      write_csr(CSR_NODE_ADDRESS, NODE_W'({$urandom, $urandom}));
      write_csr(CSR_CLOCK_SEQ_SEED, 48'h2000);
      random_readings(350);
      drain();

      // Back pressure: the receiver holds off for a long stretch while the
      // sender keeps offering forward readings, so both pipeline stages fill
      // and req_stall rises. Then the sender pauses until all UUIDs are out.
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_csr(CSR_NODE_ADDRESS, 48'h0000_0000_0001);
      write_csr(CSR_CLOCK_SEQ_SEED, 48'd1);
      holdoffs_requested++;
      repeat (20) begin
         clk_usec = clk_usec + 1;
         if (clk_usec > 999999) begin
            clk_usec = 0;
            clk_sec  = clk_sec + 1;
         end
         send_reading(clk_sec, USEC_W'(clk_usec));
      end
      drain();

      // Last phase: neither side idles, so readings stream at full rate.
      write_csr(CSR_NODE_ADDRESS, 48'h8000_0000_0000);
      random_readings(350);
      drain();

      if (failures == 0 && expected_left == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/uvtg_pkg.sv
hw/rtl/uvtg_stamp.sv
hw/rtl/uuid_v1_time_generator_core.sv
test/uuid_stamp_checker.sv
test/uuid_v1_time_generator_core_tb.sv
